// ===== hdl/water_ripple_height_step_defines.svh =====
// assertion macros for the water ripple height step checker
// no dependencies; included by files that assert
`ifndef WATER_RIPPLE_HEIGHT_STEP_DEFINES_SVH
`define WATER_RIPPLE_HEIGHT_STEP_DEFINES_SVH

// same-cycle implication
`define WRH_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wrh checker: property violated");

// next-cycle implication
`define WRH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wrh checker: property violated");

`endif

// ===== hdl/wrh_pkg.sv =====
// shared types and constants of the water ripple height step block
// no dependencies
package wrh_pkg;

   localparam int HEIGHT_BITS = 16;
   localparam int MAX_WIDTH   = 512;
   localparam int ROWS_MAX    = 1024;
   localparam int DELAY_DEPTH = MAX_WIDTH + 1;

   localparam int ROW_ADDR_BITS   = $clog2(MAX_WIDTH);
   localparam int COL_BITS        = $clog2(MAX_WIDTH + 1);
   localparam int ROW_BITS        = $clog2(ROWS_MAX);
   localparam int ROWS_CFG_BITS   = 11;
   localparam int DELAY_ADDR_BITS = $clog2(DELAY_DEPTH);
   localparam int SHIFT_BITS      = 4;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 11;

   localparam int SUM_BITS  = HEIGHT_BITS + 3;
   localparam int DIFF_BITS = HEIGHT_BITS + 2;

   localparam int FIFO_DEPTH      = 8;
   localparam int FIFO_PTR_BITS   = $clog2(FIFO_DEPTH);
   localparam int FIFO_COUNT_BITS = $clog2(FIFO_DEPTH + 1);
   localparam int PENDING_BITS    = 2;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DAMPING_SHIFT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINE_WIDTH    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_ROWS    = 2'd2;

   // register reset values
   localparam logic [SHIFT_BITS-1:0]    DAMP_RESET  = 4'd5;
   localparam logic [COL_BITS-1:0]      WIDTH_RESET = COL_BITS'(288);
   localparam logic [ROWS_CFG_BITS-1:0] ROWS_RESET  = ROWS_CFG_BITS'(224);

   // clamp limits
   localparam logic [COL_BITS-1:0]      WIDTH_MIN = COL_BITS'(3);
   localparam logic [COL_BITS-1:0]      WIDTH_MAX = COL_BITS'(MAX_WIDTH);
   localparam logic [ROWS_CFG_BITS-1:0] ROWS_MIN  = ROWS_CFG_BITS'(3);
   localparam logic [ROWS_CFG_BITS-1:0] ROWS_MAX_V = ROWS_CFG_BITS'(ROWS_MAX);

   // saturation bounds
   localparam logic signed [DIFF_BITS-1:0] SAT_HI = DIFF_BITS'((2 ** (HEIGHT_BITS - 1)) - 1);
   localparam logic signed [DIFF_BITS-1:0] SAT_LO = DIFF_BITS'(-(2 ** (HEIGHT_BITS - 1)));

   typedef logic signed [HEIGHT_BITS-1:0] height_type;

   // one window column: two rows above, one row above, current row
   typedef struct packed {
      height_type top;
      height_type mid;
      height_type bot;
   } column_type;

   // per-request flags travelling with the pixel
   typedef struct packed {
      logic produce;
      logic last;
   } tag_type;

   typedef struct packed {
      height_type height;
      logic       last;
   } result_type;

endpackage

// ===== hdl/wrh_row_store.sv =====
// two row buffers (one and two rows above) with read-modify-write per column
// depends on wrh_pkg
module wrh_row_store (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 rd_en,
   input  logic [wrh_pkg::ROW_ADDR_BITS-1:0]    rd_addr,
   input  wrh_pkg::height_type                  cur,
   output logic                                 col_valid,
   output wrh_pkg::column_type                  col
);

   wrh_pkg::height_type mem_a [wrh_pkg::MAX_WIDTH];
   wrh_pkg::height_type mem_b [wrh_pkg::MAX_WIDTH];

   wrh_pkg::height_type                 rd_a_ff, rd_b_ff;
   logic                                s1_valid_ff;
   logic [wrh_pkg::ROW_ADDR_BITS-1:0]   s1_addr_ff;
   wrh_pkg::height_type                 s1_cur_ff;
   logic                                fwd_ff;
   wrh_pkg::height_type                 fwd_a_ff, fwd_b_ff;
   wrh_pkg::height_type                 above1, above2;
   logic                                fwd_in;

   // previous request writes this column in the same cycle as the read
   assign fwd_in = s1_valid_ff && (s1_addr_ff == rd_addr);

   assign above1 = fwd_ff ? fwd_a_ff : rd_a_ff;
   assign above2 = fwd_ff ? fwd_b_ff : rd_b_ff;

   assign col_valid = s1_valid_ff;
   assign col      = '{top: above2, mid: above1, bot: s1_cur_ff};

   // row memories: read on request, write back in the cycle after
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem_a[rd_addr];
         rd_b_ff <= mem_b[rd_addr];
      end
      if (s1_valid_ff) begin
         mem_a[s1_addr_ff] <= s1_cur_ff;
         mem_b[s1_addr_ff] <= above1;
      end
   end

   // stage one payload and forwarding values
   always_ff @(posedge clock) begin
      if (rd_en) begin
         s1_addr_ff <= rd_addr;
         s1_cur_ff  <= cur;
         fwd_ff     <= fwd_in;
         fwd_a_ff   <= s1_cur_ff;
         fwd_b_ff   <= above1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= rd_en;
      end
   end

endmodule

// ===== hdl/wrh_older_delay.sv =====
// delay line for the older field, delayed by line width plus one pixels
// depends on wrh_pkg
module wrh_older_delay (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic [wrh_pkg::COL_BITS-1:0]    width,
   input  wrh_pkg::height_type             older,
   output wrh_pkg::height_type             delayed
);

   wrh_pkg::height_type mem [wrh_pkg::DELAY_DEPTH];

   logic [wrh_pkg::DELAY_ADDR_BITS-1:0] wr_pos_ff, wr_pos_in;
   logic [wrh_pkg::DELAY_ADDR_BITS:0]   rd_sum;
   logic [wrh_pkg::DELAY_ADDR_BITS-1:0] rd_addr;
   wrh_pkg::height_type                 rd_ff;

   // read position: write position minus (width + 1), modulo depth
   always_comb begin
      rd_sum = {1'b0, wr_pos_ff}
             + ((wrh_pkg::DELAY_ADDR_BITS + 1)'(wrh_pkg::MAX_WIDTH)
             - (wrh_pkg::DELAY_ADDR_BITS + 1)'(width));
      if (rd_sum >= (wrh_pkg::DELAY_ADDR_BITS + 1)'(wrh_pkg::DELAY_DEPTH)) begin
         rd_sum = rd_sum - (wrh_pkg::DELAY_ADDR_BITS + 1)'(wrh_pkg::DELAY_DEPTH);
      end
      rd_addr = rd_sum[wrh_pkg::DELAY_ADDR_BITS-1:0];
   end

   always_comb begin
      if (wr_pos_ff == wrh_pkg::DELAY_ADDR_BITS'(wrh_pkg::DELAY_DEPTH - 1)) begin
         wr_pos_in = '0;
      end else begin
         wr_pos_in = wr_pos_ff + 1'b1;
      end
   end

   // read before write, so a full-depth delay returns the oldest entry
   always_ff @(posedge clock) begin
      if (en) begin
         rd_ff          <= mem[rd_addr];
         mem[wr_pos_ff] <= older;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pos_ff <= '0;
      end else if (en) begin
         wr_pos_ff <= wr_pos_in;
      end
   end

   assign delayed = rd_ff;

endmodule

// ===== hdl/wrh_kernel.sv =====
// 3x3 window, eight-neighbour sum, older subtraction, damping and saturation
// depends on wrh_pkg
module wrh_kernel (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                col_valid,
   input  wrh_pkg::column_type                 col,
   input  wrh_pkg::tag_type                    tag,
   input  wrh_pkg::height_type                 older_delayed,
   input  logic [wrh_pkg::SHIFT_BITS-1:0]      damping_shift,
   output logic                                push,
   output wrh_pkg::result_type                 result,
   output logic [wrh_pkg::PENDING_BITS-1:0]    pending
);

   wrh_pkg::column_type win1_ff, win2_ff, win3_ff;

   logic                                  s2_valid_ff, s2_last_ff;
   wrh_pkg::height_type                   s2_older_ff;
   logic                                  s3_valid_ff, s3_last_ff;
   logic signed [wrh_pkg::SUM_BITS-1:0]   s3_sum_ff, sum_in;
   wrh_pkg::height_type                   s3_older_ff;
   logic                                  s4_valid_ff, s4_last_ff;
   logic signed [wrh_pkg::DIFF_BITS-1:0]  s4_d_ff, d_in;
   logic signed [wrh_pkg::DIFF_BITS-1:0]  damped;
   wrh_pkg::height_type                   sat;

   // window shift, once per pixel
   always_ff @(posedge clock) begin
      if (reset) begin
         win1_ff <= '0;
         win2_ff <= '0;
         win3_ff <= '0;
      end else if (col_valid) begin
         win3_ff <= win2_ff;
         win2_ff <= win1_ff;
         win1_ff <= col;
      end
   end

   // eight neighbours, centre left out
   always_comb begin
      sum_in = wrh_pkg::SUM_BITS'(win3_ff.top) + wrh_pkg::SUM_BITS'(win3_ff.mid)
             + wrh_pkg::SUM_BITS'(win3_ff.bot) + wrh_pkg::SUM_BITS'(win2_ff.top)
             + wrh_pkg::SUM_BITS'(win2_ff.bot) + wrh_pkg::SUM_BITS'(win1_ff.top)
             + wrh_pkg::SUM_BITS'(win1_ff.mid) + wrh_pkg::SUM_BITS'(win1_ff.bot);
   end

   // quarter of the sum minus the older height
   always_comb begin
      d_in = wrh_pkg::DIFF_BITS'(s3_sum_ff >>> 2) - wrh_pkg::DIFF_BITS'(s3_older_ff);
   end

   // damping and saturation
   always_comb begin
      damped = s4_d_ff - (s4_d_ff >>> damping_shift);
      if (damped > wrh_pkg::SAT_HI) begin
         sat = wrh_pkg::SAT_HI[wrh_pkg::HEIGHT_BITS-1:0];
      end else if (damped < wrh_pkg::SAT_LO) begin
         sat = wrh_pkg::SAT_LO[wrh_pkg::HEIGHT_BITS-1:0];
      end else begin
         sat = damped[wrh_pkg::HEIGHT_BITS-1:0];
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      s2_last_ff  <= tag.last;
      s2_older_ff <= older_delayed;
      s3_last_ff  <= s2_last_ff;
      s3_sum_ff   <= sum_in;
      s3_older_ff <= s2_older_ff;
      s4_last_ff  <= s3_last_ff;
      s4_d_ff     <= d_in;
   end

   // pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= col_valid && tag.produce;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   assign push    = s4_valid_ff;
   assign result  = '{height: sat, last: s4_last_ff};
   assign pending = wrh_pkg::PENDING_BITS'({1'b0, s2_valid_ff})
                  + wrh_pkg::PENDING_BITS'({1'b0, s3_valid_ff})
                  + wrh_pkg::PENDING_BITS'({1'b0, s4_valid_ff});

endmodule

// ===== hdl/wrh_result_fifo.sv =====
// result queue between the kernel pipeline and the response port
// depends on wrh_pkg
module wrh_result_fifo (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  push,
   input  wrh_pkg::result_type                   push_data,
   input  logic                                  pop,
   output logic                                  not_empty,
   output wrh_pkg::result_type                   head,
   output logic [wrh_pkg::FIFO_COUNT_BITS-1:0]   count
);

   wrh_pkg::result_type                    slot_ff [wrh_pkg::FIFO_DEPTH];
   logic [wrh_pkg::FIFO_PTR_BITS-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [wrh_pkg::FIFO_COUNT_BITS-1:0]    count_ff;

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

// ===== hdl/water_ripple_height_step.sv =====
// water ripple height step: 8-neighbour wave update on a raster pixel stream
// a response passes the row store stage, the kernel stages and the result queue
// throughput: one request per cycle; the row memories are read-modify-write
// with one read and one write port each, and ready drops only when eight
// results are queued or in flight. synchronous reset clears counters, queue
// and window; row and delay memories are not cleared and need no pass.
module water_ripple_height_step (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  wrh_pkg::height_type                 req_cur_height,
   input  wrh_pkg::height_type                 req_older_height,
   input  logic                                req_frame_start,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output wrh_pkg::height_type                 rsp_new_height,
   output logic                                rsp_frame_last,
   input  logic                                csr_wr_en,
   input  logic [wrh_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [wrh_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   logic [wrh_pkg::SHIFT_BITS-1:0]      damp_ff;
   logic [wrh_pkg::COL_BITS-1:0]        width_ff;
   logic [wrh_pkg::ROWS_CFG_BITS-1:0]   rows_ff;

   logic [wrh_pkg::COL_BITS-1:0]        width_c;
   logic [wrh_pkg::ROWS_CFG_BITS-1:0]   rows_c;

   logic [wrh_pkg::COL_BITS-1:0]        col_ff, col_in, col_raw, col_cur, col_inc;
   logic [wrh_pkg::ROW_BITS-1:0]        row_ff, row_in, row_raw, row_cur;
   logic [wrh_pkg::ROWS_CFG_BITS-1:0]   row_inc;

   logic                                accept;
   wrh_pkg::tag_type                    tag_in, s1_tag_ff;

   logic                                col_valid;
   wrh_pkg::column_type                 col;
   wrh_pkg::height_type                 older_dly;
   logic                                push;
   wrh_pkg::result_type                 result, head;
   logic [wrh_pkg::PENDING_BITS-1:0]    pending;
   logic [wrh_pkg::FIFO_COUNT_BITS-1:0] fifo_count;
   logic [wrh_pkg::FIFO_COUNT_BITS:0]   credit_used;
   logic                                not_empty;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         damp_ff  <= wrh_pkg::DAMP_RESET;
         width_ff <= wrh_pkg::WIDTH_RESET;
         rows_ff  <= wrh_pkg::ROWS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            wrh_pkg::CSR_DAMPING_SHIFT: damp_ff  <= csr_wdata[wrh_pkg::SHIFT_BITS-1:0];
            wrh_pkg::CSR_LINE_WIDTH:    width_ff <= csr_wdata[wrh_pkg::COL_BITS-1:0];
            wrh_pkg::CSR_FRAME_ROWS:    rows_ff  <= csr_wdata[wrh_pkg::ROWS_CFG_BITS-1:0];
            default: ;
         endcase
      end
   end

   // clamped geometry
   always_comb begin
      if (width_ff < wrh_pkg::WIDTH_MIN) begin
         width_c = wrh_pkg::WIDTH_MIN;
      end else if (width_ff > wrh_pkg::WIDTH_MAX) begin
         width_c = wrh_pkg::WIDTH_MAX;
      end else begin
         width_c = width_ff;
      end
      if (rows_ff < wrh_pkg::ROWS_MIN) begin
         rows_c = wrh_pkg::ROWS_MIN;
      end else if (rows_ff > wrh_pkg::ROWS_MAX_V) begin
         rows_c = wrh_pkg::ROWS_MAX_V;
      end else begin
         rows_c = rows_ff;
      end
   end

   // raster position of this request and of the next one
   always_comb begin
      col_raw = req_frame_start ? '0 : col_ff;
      row_raw = req_frame_start ? '0 : row_ff;
      col_cur = (col_raw >= width_c) ? '0 : col_raw;
      row_cur = (wrh_pkg::ROWS_CFG_BITS'(row_raw) >= rows_c) ? '0 : row_raw;

      tag_in.produce = (row_cur >= wrh_pkg::ROW_BITS'(2)) && (col_cur >= wrh_pkg::COL_BITS'(2));
      tag_in.last    = (wrh_pkg::ROWS_CFG_BITS'(row_cur) == rows_c - 1'b1)
                    && (col_cur == width_c - 1'b1);

      col_inc = col_cur + 1'b1;
      row_inc = wrh_pkg::ROWS_CFG_BITS'(row_cur) + 1'b1;
      if (col_inc >= width_c) begin
         col_in = '0;
         row_in = (row_inc >= rows_c) ? '0 : row_inc[wrh_pkg::ROW_BITS-1:0];
      end else begin
         col_in = col_inc;
         row_in = row_cur;
      end
   end

   // room for every result queued or in flight
   assign credit_used = (wrh_pkg::FIFO_COUNT_BITS + 1)'(fifo_count)
                      + (wrh_pkg::FIFO_COUNT_BITS + 1)'(pending)
                      + (wrh_pkg::FIFO_COUNT_BITS + 1)'(s1_tag_ff.produce);
   assign req_ready   = credit_used < (wrh_pkg::FIFO_COUNT_BITS + 1)'(wrh_pkg::FIFO_DEPTH);
   assign accept      = req_valid && req_ready;

   // position counters and stage one flags
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         s1_tag_ff <= '0;
      end else begin
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         s1_tag_ff <= accept ? tag_in : '0;
      end
   end

   wrh_row_store u_rows (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr   (col_cur[wrh_pkg::ROW_ADDR_BITS-1:0]),
      .cur       (req_cur_height),
      .col_valid (col_valid),
      .col       (col)
   );

   wrh_older_delay u_delay (
      .clock   (clock),
      .reset   (reset),
      .en      (accept),
      .width   (width_c),
      .older   (req_older_height),
      .delayed (older_dly)
   );

   wrh_kernel u_kernel (
      .clock         (clock),
      .reset         (reset),
      .col_valid     (col_valid),
      .col           (col),
      .tag           (s1_tag_ff),
      .older_delayed (older_dly),
      .damping_shift (damp_ff),
      .push          (push),
      .result        (result),
      .pending       (pending)
   );

   wrh_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (result),
      .pop       (rsp_valid && rsp_ready),
      .not_empty (not_empty),
      .head      (head),
      .count     (fifo_count)
   );

   assign rsp_valid      = not_empty;
   assign rsp_new_height = head.height;
   assign rsp_frame_last = head.last;

endmodule

// ===== hdl/wrh_checker.sv =====
// port-level checks of the water ripple height step block, bound to the top
// depends on wrh_pkg and water_ripple_height_step_defines.svh
`include "water_ripple_height_step_defines.svh"

module wrh_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input wrh_pkg::height_type rsp_new_height,
   input logic                rsp_frame_last
);

   // a stalled response holds its payload
   `WRH_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_new_height) && $stable(rsp_frame_last))

   // reset flushes queued responses
   `WRH_ASSERT_NEXT(a_reset_flush, clock, 1'b0, reset, !rsp_valid)

   // with nothing queued there is always room for a request
   `WRH_ASSERT_SAME(a_empty_ready, clock, reset, !rsp_valid, req_ready)

   // a response appearing from empty traces back to an accepted request
   `WRH_ASSERT_SAME(a_rsp_cause, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready, 5))

endmodule

bind water_ripple_height_step wrh_checker u_wrh_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_new_height (rsp_new_height),
   .rsp_frame_last (rsp_frame_last)
);

// ===== sim/water_ripple_height_step_tb.sv =====
`timescale 1ns / 1ps
// testbench for water_ripple_height_step: pixel requests in, damped heights out, checked in order
// keeps its own copy of the line buffers, delay line and window to predict each response
// depends on wrh_pkg and the water_ripple_height_step rtl
module water_ripple_height_step_tb;

   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_ITEMS = 540;
   localparam int PRINT_LIMIT  = 100;
   localparam logic [wrh_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE = 2'd3;

   typedef enum {
      FILL_RANDOM,
      FILL_EXTREME,
      FILL_SMALL,
      FILL_SWELL,
      FILL_TROUGH
   } fill_style_type;

   logic clock = 1'b0;
   logic reset;

   logic                               req_valid;
   logic                               req_ready;
   wrh_pkg::height_type                req_cur_height;
   wrh_pkg::height_type                req_older_height;
   logic                               req_frame_start;
   logic                               rsp_valid;
   logic                               rsp_ready;
   wrh_pkg::height_type                rsp_new_height;
   logic                               rsp_frame_last;
   logic                               csr_wr_en;
   logic [wrh_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [wrh_pkg::CSR_DATA_BITS-1:0]  csr_wdata;

   // local copy of the block's registers and storage
   logic [wrh_pkg::SHIFT_BITS-1:0]    damp_shift;
   logic [wrh_pkg::COL_BITS-1:0]      width_reg;
   logic [wrh_pkg::ROWS_CFG_BITS-1:0] rows_reg;
   wrh_pkg::height_type               above_one [wrh_pkg::MAX_WIDTH];
   wrh_pkg::height_type               above_two [wrh_pkg::MAX_WIDTH];
   wrh_pkg::height_type               older_line [wrh_pkg::DELAY_DEPTH];
   wrh_pkg::height_type               win [3][3];
   int unsigned                       col_pos;
   int unsigned                       row_pos;
   int unsigned                       older_wr;

   wrh_pkg::result_type damped_heights [$];
   int                  error_count;
   int                  pixels_sent;
   bit                  src_gaps;
   bit                  sink_gaps;
   bit                  counters_aligned;

   water_ripple_height_step u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cur_height   (req_cur_height),
      .req_older_height (req_older_height),
      .req_frame_start  (req_frame_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_new_height   (rsp_new_height),
      .rsp_frame_last   (rsp_frame_last),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // hard stop if the run hangs
   initial begin : watchdog
      #(2_000_000);
      $display("water_ripple_height_step: mismatch");
      $finish;
   end

   function automatic int eff_width();
      int w;
      w = int'(width_reg);
      if (w < 3) w = 3;
      if (w > wrh_pkg::MAX_WIDTH) w = wrh_pkg::MAX_WIDTH;
      return w;
   endfunction

   function automatic int eff_rows();
      int h;
      h = int'(rows_reg);
      if (h < 3) h = 3;
      if (h > wrh_pkg::ROWS_MAX) h = wrh_pkg::ROWS_MAX;
      return h;
   endfunction

   function automatic void clear_model();
      int i;
      damp_shift = wrh_pkg::DAMP_RESET;
      width_reg  = wrh_pkg::WIDTH_RESET;
      rows_reg   = wrh_pkg::ROWS_RESET;
      for (i = 0; i < wrh_pkg::MAX_WIDTH; i++) begin
         above_one[i] = '0;
         above_two[i] = '0;
      end
      for (i = 0; i < wrh_pkg::DELAY_DEPTH; i++) older_line[i] = '0;
      for (i = 0; i < 9; i++) win[i / 3][i % 3] = '0;
      col_pos  = 0;
      row_pos  = 0;
      older_wr = 0;
   endfunction

   // one pixel through the window: returns 1 when the centre is interior
   function automatic bit ripple_step(input wrh_pkg::height_type cur,
                                      input wrh_pkg::height_type older,
                                      input logic start, output wrh_pkg::result_type res);
      int unsigned                          w, h, c, r, rd;
      int                                   i;
      wrh_pkg::height_type                  up1, up2, delayed;
      logic signed [wrh_pkg::SUM_BITS-1:0]  ring;
      logic signed [wrh_pkg::DIFF_BITS-1:0] diff, damped;
      bit                                   made;
      w = eff_width();
      h = eff_rows();
      if (start) begin
         col_pos = 0;
         row_pos = 0;
      end
      c = col_pos;
      r = row_pos;
      if (c >= w) c = 0;
      if (r >= h) r = 0;

      // row memories: one and two rows above
      up1 = above_one[c];
      up2 = above_two[c];
      above_two[c] = up1;
      above_one[c] = cur;

      for (i = 0; i < 3; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2] = up2;
      win[1][2] = up1;
      win[2][2] = cur;

      // older height of the centre, w+1 pixels back
      if (older_wr >= wrh_pkg::DELAY_DEPTH) older_wr = 0;
      rd = (older_wr + wrh_pkg::DELAY_DEPTH - (w + 1)) % wrh_pkg::DELAY_DEPTH;
      delayed = older_line[rd];
      older_line[older_wr] = older;
      older_wr = (older_wr + 1) % wrh_pkg::DELAY_DEPTH;

      made = 1'b0;
      res  = '0;
      if (r >= 2 && c >= 2) begin
         ring = wrh_pkg::SUM_BITS'(win[0][0]) + wrh_pkg::SUM_BITS'(win[0][1])
              + wrh_pkg::SUM_BITS'(win[0][2]) + wrh_pkg::SUM_BITS'(win[1][0])
              + wrh_pkg::SUM_BITS'(win[1][2]) + wrh_pkg::SUM_BITS'(win[2][0])
              + wrh_pkg::SUM_BITS'(win[2][1]) + wrh_pkg::SUM_BITS'(win[2][2]);
         diff   = wrh_pkg::DIFF_BITS'(ring >>> 2) - wrh_pkg::DIFF_BITS'(delayed);
         damped = diff - (diff >>> damp_shift);
         if (damped > wrh_pkg::SAT_HI)
            res.height = wrh_pkg::SAT_HI[wrh_pkg::HEIGHT_BITS-1:0];
         else if (damped < wrh_pkg::SAT_LO)
            res.height = wrh_pkg::SAT_LO[wrh_pkg::HEIGHT_BITS-1:0];
         else
            res.height = damped[wrh_pkg::HEIGHT_BITS-1:0];
         res.last = (r == h - 1) && (c == w - 1);
         made = 1'b1;
      end

      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      col_pos = c;
      row_pos = r;
      return made;
   endfunction

   function automatic wrh_pkg::height_type pick_height(input fill_style_type fill,
                                                       input bit is_older);
      case (fill)
         FILL_EXTREME: begin
            case ($urandom_range(0, 3))
               0: return 16'sh7FFF;
               1: return 16'sh8000;
               2: return 16'sh0000;
               default: return 16'shFFFF;
            endcase
         end
         FILL_SMALL: return wrh_pkg::height_type'(int'($urandom_range(0, 400)) - 200);
         FILL_SWELL: begin
            if (is_older) return wrh_pkg::height_type'(-32768 + int'($urandom_range(0, 100)));
            else return wrh_pkg::height_type'(32767 - int'($urandom_range(0, 100)));
         end
         FILL_TROUGH: begin
            if (is_older) return wrh_pkg::height_type'(32767 - int'($urandom_range(0, 100)));
            else return wrh_pkg::height_type'(-32768 + int'($urandom_range(0, 100)));
         end
         default: return wrh_pkg::height_type'($urandom);
      endcase
   endfunction

   task automatic flag_mismatch(input string what, input int got, input int want);
      if (error_count < PRINT_LIMIT)
         $display("%0t: %s, got %0d, want %0d", $time, what, got, want);
      error_count++;
   endtask

   // one request, held until accepted; prediction made as it is offered
   task automatic send_pixel(input wrh_pkg::height_type cur, input wrh_pkg::height_type older,
                             input logic start);
      int                  gap;
      wrh_pkg::result_type res;
      gap = src_gaps ? int'($urandom_range(0, 6)) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_cur_height   <= cur;
      req_older_height <= older;
      req_frame_start  <= start;
      if (ripple_step(cur, older, start, res)) damped_heights.push_back(res);
      pixels_sent++;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // stop sending and let every expected response come out
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (damped_heights.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [wrh_pkg::CSR_INDEX_BITS-1:0] index,
                            input logic [wrh_pkg::CSR_DATA_BITS-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      case (index)
         wrh_pkg::CSR_DAMPING_SHIFT: damp_shift = data[wrh_pkg::SHIFT_BITS-1:0];
         wrh_pkg::CSR_LINE_WIDTH:    width_reg  = data[wrh_pkg::COL_BITS-1:0];
         wrh_pkg::CSR_FRAME_ROWS:    rows_reg   = data[wrh_pkg::ROWS_CFG_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // a frame, or the first cut pixels of one; pause_at drains mid-frame
   task automatic send_frame(input fill_style_type fill, input bit mark, input int cut,
                             input int pause_at);
      int total;
      int i;
      total = eff_width() * eff_rows();
      for (i = 0; i < cut; i++) begin
         if (i == pause_at) wait_idle();
         send_pixel(pick_height(fill, 1'b0), pick_height(fill, 1'b1), mark && (i == 0));
      end
      counters_aligned = (cut == total);
   endtask

   // reset values: width 288 and shift 5, counters at zero without a start mark
   task automatic test_reset_values();
      src_gaps  = 1'b1;
      sink_gaps = 1'b1;
      send_frame(FILL_RANDOM, 1'b0, 2 * 288 + 10, -1);
      wait_idle();
   endtask

   // smallest frame: saturation both ways, weakest damping and zero shift
   task automatic test_saturation_and_shift();
      write_reg(wrh_pkg::CSR_DAMPING_SHIFT, wrh_pkg::CSR_DATA_BITS'(15));
      write_reg(wrh_pkg::CSR_LINE_WIDTH, wrh_pkg::CSR_DATA_BITS'(3));
      write_reg(wrh_pkg::CSR_FRAME_ROWS, wrh_pkg::CSR_DATA_BITS'(3));
      send_frame(FILL_SWELL, 1'b1, 9, -1);
      send_frame(FILL_TROUGH, 1'b0, 9, -1);
      wait_idle();
      write_reg(wrh_pkg::CSR_DAMPING_SHIFT, wrh_pkg::CSR_DATA_BITS'(0));
      send_frame(FILL_EXTREME, 1'b0, 9, -1);
      wait_idle();
   endtask

   // width and row counts outside the legal range are clamped
   task automatic test_size_clamps();
      write_reg(wrh_pkg::CSR_DAMPING_SHIFT, wrh_pkg::CSR_DATA_BITS'(2));
      write_reg(wrh_pkg::CSR_LINE_WIDTH, wrh_pkg::CSR_DATA_BITS'(0));
      write_reg(wrh_pkg::CSR_FRAME_ROWS, wrh_pkg::CSR_DATA_BITS'(1));
      send_frame(FILL_RANDOM, 1'b1, eff_width() * eff_rows(), -1);
      wait_idle();
      write_reg(wrh_pkg::CSR_LINE_WIDTH, wrh_pkg::CSR_DATA_BITS'(2));
      write_reg(wrh_pkg::CSR_FRAME_ROWS, wrh_pkg::CSR_DATA_BITS'(2));
      write_reg(CSR_SPARE, '1);
      send_frame(FILL_EXTREME, 1'b1, eff_width() * eff_rows(), -1);
      wait_idle();
      // upper data bits beyond each register are dropped
      write_reg(wrh_pkg::CSR_DAMPING_SHIFT, 11'h7F3);
      write_reg(wrh_pkg::CSR_LINE_WIDTH, 11'h404);
      write_reg(wrh_pkg::CSR_FRAME_ROWS, wrh_pkg::CSR_DATA_BITS'(0));
      src_gaps  = 1'b0;
      sink_gaps = 1'b0;
      send_frame(FILL_RANDOM, 1'b1, eff_width() * eff_rows(), -1);
      wait_idle();
      // row count above the limit, first rows of a long frame
      write_reg(wrh_pkg::CSR_LINE_WIDTH, wrh_pkg::CSR_DATA_BITS'(3));
      write_reg(wrh_pkg::CSR_FRAME_ROWS, 11'h7FF);
      src_gaps  = 1'b1;
      sink_gaps = 1'b1;
      send_frame(FILL_SMALL, 1'b1, 60, 30);
      wait_idle();
   endtask

   // start mark mid-frame, and frames that follow on without a mark
   task automatic test_restart_and_wrap();
      write_reg(wrh_pkg::CSR_DAMPING_SHIFT, wrh_pkg::CSR_DATA_BITS'(4));
      write_reg(wrh_pkg::CSR_LINE_WIDTH, wrh_pkg::CSR_DATA_BITS'(6));
      write_reg(wrh_pkg::CSR_FRAME_ROWS, wrh_pkg::CSR_DATA_BITS'(5));
      send_frame(FILL_RANDOM, 1'b1, 17, -1);
      send_frame(FILL_RANDOM, 1'b1, 30, -1);
      send_frame(FILL_SMALL, 1'b0, 30, -1);
      send_frame(FILL_RANDOM, 1'b1, 30, -1);
      wait_idle();
   endtask

   // random small frames with random settings, cut frames and drains
   task automatic test_random_frames();
      int base;
      int total;
      int cut;
      int pause_at;
      bit mark;
      base = pixels_sent;
      while (pixels_sent - base < RANDOM_ITEMS) begin
         src_gaps  = ($urandom_range(0, 3) != 0);
         sink_gaps = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 3) == 0) begin
            wait_idle();
            if ($urandom_range(0, 1))
               write_reg(wrh_pkg::CSR_DAMPING_SHIFT,
                         wrh_pkg::CSR_DATA_BITS'($urandom_range(0, 15)));
            if ($urandom_range(0, 1))
               write_reg(wrh_pkg::CSR_LINE_WIDTH,
                         wrh_pkg::CSR_DATA_BITS'($urandom_range(0, 18)));
            if ($urandom_range(0, 1))
               write_reg(wrh_pkg::CSR_FRAME_ROWS,
                         wrh_pkg::CSR_DATA_BITS'($urandom_range(0, 8)));
         end
         total    = eff_width() * eff_rows();
         cut      = ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, total - 1)) : total;
         mark     = !counters_aligned || ($urandom_range(0, 1) == 1);
         pause_at = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, cut - 1)) : -1;
         send_frame(fill_style_type'($urandom_range(0, 4)), mark, cut, pause_at);
      end
      wait_idle();
   endtask

   // response side: random stalls, each response checked against the oldest prediction
   initial begin : result_monitor
      int                  stall;
      wrh_pkg::result_type want;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = sink_gaps ? int'($urandom_range(0, 6)) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (damped_heights.size() == 0) begin
            flag_mismatch("response with none expected", int'(rsp_new_height), 0);
         end else begin
            want = damped_heights.pop_front();
            if (rsp_new_height !== want.height)
               flag_mismatch("new_height", int'(rsp_new_height), int'(want.height));
            if (rsp_frame_last !== want.last)
               flag_mismatch("frame_last", int'(rsp_frame_last), int'(want.last));
         end
      end
   end

   initial begin : stimulus
      error_count      = 0;
      pixels_sent      = 0;
      src_gaps         = 1'b0;
      sink_gaps        = 1'b0;
      counters_aligned = 1'b1;
      clear_model();
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_cur_height   <= '0;
      req_older_height <= '0;
      req_frame_start  <= 1'b0;
      csr_wr_en        <= 1'b0;
      csr_index        <= '0;
      csr_wdata        <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_saturation_and_shift();
      test_size_clamps();
      test_restart_and_wrap();
      test_random_frames();

      wait_idle();
      if (error_count == 0 && damped_heights.size() == 0) begin
         $display("water_ripple_height_step: match");
      end else begin
         $display("water_ripple_height_step: mismatch");
      end
      $finish;
   end

endmodule

// ===== water_ripple_height_step.f =====
+incdir+hdl
hdl/wrh_pkg.sv
hdl/wrh_row_store.sv
hdl/wrh_older_delay.sv
hdl/wrh_kernel.sv
hdl/wrh_result_fifo.sv
hdl/water_ripple_height_step.sv
hdl/wrh_checker.sv
sim/water_ripple_height_step_tb.sv
